// ===== rtl/ftl_pkg.sv =====
`default_nettype none
package ftl_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] logical_page;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  src_block;
    logic [3:0]  src_page;
    logic [3:0]  dst_block;
    logic [3:0]  dst_page;
    logic [6:0]  moved_logical_page;
    logic [1:0]  status;
    logic [31:0] flash_write_count;
    logic        last;
  } rsp_t;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_FORMAT = 2'd2;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_NO_FREE  = 2'd2;
  localparam logic [1:0] ST_GC_FULL  = 2'd3;

  localparam logic [4:0] THRESHOLD_RESET = 5'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OUT,
    S_BADWR,
    S_FORMAT,
    S_WR_OLD,
    S_WR_STALE,
    S_WR_PTR,
    S_SCAN_FREE,
    S_GC_SCAN,
    S_GC_READ,
    S_GC_MOVE,
    S_GC_ERASE,
    S_PROGRAM,
    S_FAIL
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/page_mapping_ftl_with_greedy_gc_core.sv =====
`default_nettype none
// page-mapped flash translation engine with greedy garbage collection. one
// request is worked on at a time; in_stall is high while it runs. a write
// whose write block is full first does a round-robin free block search, or
// a collection: a victim scan over all blocks, a page map read for each page
// of the victim block with a move of each valid one, and then an erase. a
// result waits while an earlier result is held by out_stall. the logical map
// and the page owner/mark table live in single-port-write synchronous rams;
// their valid bits are flip-flops, so reset and format take effect at once.
module page_mapping_ftl_with_greedy_gc_core
  import ftl_pkg::*;
#(
  parameter int PAGES_PER_BLOCK = 10,
  parameter int PHYS_BLOCKS     = 16,
  parameter int LOGICAL_BLOCKS  = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire req_t       in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output rsp_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data
);

  localparam int LPAGES = LOGICAL_BLOCKS * PAGES_PER_BLOCK;
  localparam int PPAGES = PHYS_BLOCKS * PAGES_PER_BLOCK;
  localparam int BLK_W  = $clog2(PHYS_BLOCKS);
  localparam int PG_W   = $clog2(PAGES_PER_BLOCK);
  localparam int CNT_W  = $clog2(PAGES_PER_BLOCK + 2);
  localparam int FB_W   = $clog2(PHYS_BLOCKS + 1);
  localparam int LA_W   = $clog2(LPAGES);
  localparam int PA_W   = $clog2(PPAGES);
  localparam int LM_W   = BLK_W + PG_W;
  localparam int PM_W   = 9;

  function automatic logic [PA_W-1:0] paddr(input logic [BLK_W-1:0] blk,
                                            input logic [PG_W-1:0] pg);
    return PA_W'(int'(blk) * PAGES_PER_BLOCK + int'(pg));
  endfunction

  state_t state, state_next;

  logic [6:0]       lpn_r;
  logic [BLK_W-1:0] wb;
  logic [PG_W-1:0]  wp;
  logic             started;
  logic [FB_W-1:0]  fb;
  logic [BLK_W-1:0] spare;
  logic [31:0]      pw;
  logic [4:0]       thr;
  logic [CNT_W-1:0] bvc [PHYS_BLOCKS];
  logic [PHYS_BLOCKS-1:0] bfree;
  logic [LPAGES-1:0] lvalid;
  logic [PPAGES-1:0] pvalid;
  logic [BLK_W-1:0] scan_b;
  logic [BLK_W-1:0] scan_cnt;
  logic [CNT_W-1:0] best;
  logic [BLK_W-1:0] target;
  logic             found;
  logic [BLK_W-1:0] dst;
  logic [PG_W-1:0]  gi;
  logic [PG_W:0]    gpg;
  logic [1:0]       status_r;

  logic            lm_we;
  logic [LA_W-1:0] lm_waddr, lm_raddr;
  logic [LM_W-1:0] lm_wdata, lm_rdata;
  logic            pm_we;
  logic [PA_W-1:0] pm_waddr, pm_raddr;
  logic [PM_W-1:0] pm_wdata, pm_rdata;

  logic            accept, ofree, emit, pw_bump, fmt_go;
  rsp_t            emit_data;
  logic [LA_W-1:0] la_r;
  logic            in_range_r;
  logic [BLK_W-1:0] old_blk;
  logic [PG_W-1:0]  old_pg;
  logic [PA_W-1:0]  old_a, src_a;
  logic            pm_stale, pm_tag;
  logic [6:0]      pm_lpn;
  logic            do_stale, free_hit, gc_hit, gc_fnd, mv, scan_last;
  logic [BLK_W-1:0] scan_b_nx;
  logic [31:0]     pw_inc;
  logic [FB_W-1:0] fb_dec, fb_erase;

  ftl_ram #(.WIDTH(LM_W), .DEPTH(LPAGES)) u_lmap (
    .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
    .raddr(lm_raddr), .rdata(lm_rdata)
  );

  ftl_ram #(.WIDTH(PM_W), .DEPTH(PPAGES)) u_pmap (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata)
  );

  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && !in_stall;
  assign ofree      = !out_valid || !out_stall;
  assign la_r       = LA_W'(lpn_r);
  assign in_range_r = (32'(lpn_r) < LPAGES);
  assign old_blk    = lm_rdata[LM_W-1:PG_W];
  assign old_pg     = lm_rdata[PG_W-1:0];
  assign old_a      = paddr(old_blk, old_pg);
  assign src_a      = paddr(target, gi);
  assign pm_stale   = pm_rdata[8];
  assign pm_tag     = pm_rdata[7];
  assign pm_lpn     = pm_rdata[6:0];
  assign pw_inc     = (pw == 32'hFFFF_FFFF) ? pw : pw + 32'd1;
  assign fb_dec     = (fb != '0) ? fb - 1'b1 : fb;
  // return one block, take one: only a full count moves
  assign fb_erase   = (32'(fb) == PHYS_BLOCKS) ? FB_W'(PHYS_BLOCKS - 1) : fb;
  assign scan_last  = (32'(scan_b) == PHYS_BLOCKS - 1);
  assign scan_b_nx  = scan_last ? '0 : scan_b + 1'b1;
  assign do_stale   = pvalid[old_a] && !pm_stale;
  assign free_hit   = bfree[scan_b] && (scan_b != spare);
  assign gc_hit     = !bfree[scan_b] && (scan_b != spare) && (bvc[scan_b] < best);
  assign gc_fnd     = found || gc_hit;
  assign mv         = pvalid[src_a] && !pm_stale && (32'(gpg) < PAGES_PER_BLOCK);
  assign fmt_go     = (state == S_FORMAT) && ofree;

  always_comb begin
    state_next = state;
    lm_we      = 1'b0;
    lm_waddr   = la_r;
    lm_wdata   = {wb, wp};
    lm_raddr   = (state == S_IDLE) ? LA_W'(in_data.logical_page) : la_r;
    pm_we      = 1'b0;
    pm_waddr   = paddr(wb, wp);
    pm_wdata   = {1'b0, 1'b1, lpn_r};
    pm_raddr   = (state == S_GC_READ || state == S_GC_MOVE) ? src_a : old_a;
    emit       = 1'b0;
    pw_bump    = 1'b0;
    emit_data  = '0;
    emit_data.flash_write_count  = pw;
    emit_data.last               = 1'b1;
    emit_data.moved_logical_page = lpn_r;
    emit_data.kind               = KIND_DONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_READ:   state_next = S_RD_OUT;
            OP_WRITE:  state_next = (32'(in_data.logical_page) < LPAGES) ? S_WR_OLD : S_BADWR;
            OP_FORMAT: state_next = S_FORMAT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_RD_OUT: begin
        emit_data.kind = KIND_READ;
        if (in_range_r && lvalid[la_r]) begin
          emit_data.dst_block = 4'(old_blk);
          emit_data.dst_page  = 4'(old_pg);
          emit_data.status    = ST_OK;
        end else begin
          emit_data.status = ST_UNMAPPED;
        end
        if (ofree) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BADWR: begin
        emit_data.status = ST_UNMAPPED;
        if (ofree) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FORMAT: begin
        emit_data.moved_logical_page = '0;
        if (ofree) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WR_OLD: begin
        state_next = lvalid[la_r] ? S_WR_STALE : S_WR_PTR;
      end
      S_WR_STALE: begin
        if (do_stale) begin
          pm_we    = 1'b1;
          pm_waddr = old_a;
          pm_wdata = {1'b1, pm_rdata[7:0]};
        end
        state_next = S_WR_PTR;
      end
      S_WR_PTR: begin
        if (!started) begin
          state_next = S_PROGRAM;
        end else if (32'(wp) >= PAGES_PER_BLOCK - 1) begin
          state_next = (32'(fb) <= 32'(thr)) ? S_GC_SCAN : S_SCAN_FREE;
        end else begin
          state_next = S_PROGRAM;
        end
      end
      S_SCAN_FREE: begin
        if (free_hit) begin
          state_next = S_PROGRAM;
        end else if (32'(scan_cnt) == PHYS_BLOCKS - 1) begin
          state_next = S_FAIL;
        end
      end
      S_GC_SCAN: begin
        if (scan_last) begin
          state_next = gc_fnd ? S_GC_READ : S_FAIL;
        end
      end
      S_GC_READ: begin
        state_next = S_GC_MOVE;
      end
      S_GC_MOVE: begin
        emit_data.kind               = KIND_MOVE;
        emit_data.src_block          = 4'(target);
        emit_data.src_page           = 4'(gi);
        emit_data.dst_block          = 4'(dst);
        emit_data.dst_page           = 4'(gpg);
        emit_data.moved_logical_page = pm_tag ? pm_lpn : 7'd0;
        emit_data.status             = ST_OK;
        emit_data.flash_write_count  = pw_inc;
        emit_data.last               = 1'b0;
        if (!mv || ofree) begin
          if (mv) begin
            emit     = 1'b1;
            pw_bump  = 1'b1;
            pm_we    = 1'b1;
            pm_waddr = paddr(dst, gpg[PG_W-1:0]);
            pm_wdata = {1'b0, pm_tag, pm_tag ? pm_lpn : 7'd0};
            lm_we    = pm_tag;
            lm_waddr = LA_W'(pm_lpn);
            lm_wdata = {dst, gpg[PG_W-1:0]};
          end
          state_next = (32'(gi) == PAGES_PER_BLOCK - 1) ? S_GC_ERASE : S_GC_READ;
        end
      end
      S_GC_ERASE: begin
        state_next = (32'(gpg) >= PAGES_PER_BLOCK) ? S_FAIL : S_PROGRAM;
      end
      S_PROGRAM: begin
        emit_data.dst_block         = 4'(wb);
        emit_data.dst_page          = 4'(wp);
        emit_data.status            = ST_OK;
        emit_data.flash_write_count = pw_inc;
        if (ofree) begin
          emit       = 1'b1;
          pw_bump    = 1'b1;
          pm_we      = 1'b1;
          lm_we      = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FAIL: begin
        emit_data.status = status_r;
        if (ofree) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pw        <= '0;
      thr       <= THRESHOLD_RESET;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pw_bump) begin
        pw <= pw_inc;
      end
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_data;
    end
    if (accept) begin
      lpn_r <= in_data.logical_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || fmt_go) begin
      lvalid  <= '0;
      pvalid  <= '0;
      bfree   <= '1;
      for (int b = 0; b < PHYS_BLOCKS; b++) begin
        bvc[b] <= '0;
      end
      wb      <= '0;
      wp      <= '0;
      started <= 1'b0;
      fb      <= FB_W'(PHYS_BLOCKS);
      spare   <= BLK_W'(PHYS_BLOCKS - 1);
    end else begin
      case (state)
        S_WR_STALE: begin
          if (do_stale && bvc[old_blk] != '0) begin
            bvc[old_blk] <= bvc[old_blk] - 1'b1;
          end
        end
        S_WR_PTR: begin
          if (!started) begin
            started  <= 1'b1;
            wb       <= '0;
            wp       <= '0;
            bfree[0] <= 1'b0;
            bvc[0]   <= '0;
            fb       <= fb_dec;
          end else if (32'(wp) >= PAGES_PER_BLOCK - 1) begin
            // victim scan starts at block zero, free search at the write block
            scan_b   <= (32'(fb) <= 32'(thr)) ? '0 : wb;
            scan_cnt <= '0;
            best     <= CNT_W'(PAGES_PER_BLOCK + 1);
            found    <= 1'b0;
          end else begin
            wp <= wp + 1'b1;
          end
        end
        S_SCAN_FREE: begin
          if (free_hit) begin
            wb            <= scan_b;
            wp            <= '0;
            bfree[scan_b] <= 1'b0;
            bvc[scan_b]   <= '0;
            fb            <= fb_dec;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
            scan_b   <= scan_b_nx;
            status_r <= ST_NO_FREE;
          end
        end
        S_GC_SCAN: begin
          if (gc_hit) begin
            best   <= bvc[scan_b];
            target <= scan_b;
            found  <= 1'b1;
          end
          scan_b <= scan_b_nx;
          if (scan_last) begin
            if (gc_fnd) begin
              dst          <= spare;
              bfree[spare] <= 1'b0;
              bvc[spare]   <= '0;
              gpg          <= '0;
              gi           <= '0;
            end else begin
              status_r <= ST_NO_FREE;
            end
          end
        end
        S_GC_MOVE: begin
          if (!mv || ofree) begin
            if (mv) begin
              bvc[dst] <= bvc[dst] + 1'b1;
              pvalid[paddr(dst, gpg[PG_W-1:0])] <= 1'b1;
              if (pm_tag) begin
                lvalid[LA_W'(pm_lpn)] <= 1'b1;
              end
              gpg <= gpg + 1'b1;
            end
            gi <= gi + 1'b1;
          end
        end
        S_GC_ERASE: begin
          for (int j = 0; j < PAGES_PER_BLOCK; j++) begin
            pvalid[paddr(target, PG_W'(j))] <= 1'b0;
          end
          bvc[target]   <= '0;
          bfree[target] <= 1'b1;
          fb            <= fb_erase;
          spare         <= target;
          wb            <= dst;
          if (32'(gpg) >= PAGES_PER_BLOCK) begin
            wp       <= PG_W'(PAGES_PER_BLOCK - 1);
            status_r <= ST_GC_FULL;
          end else begin
            wp <= gpg[PG_W-1:0];
          end
        end
        S_PROGRAM: begin
          if (ofree) begin
            pvalid[paddr(wb, wp)] <= 1'b1;
            bvc[wb]               <= bvc[wb] + 1'b1;
            lvalid[la_r]          <= 1'b1;
          end
        end
        S_FAIL: begin
          if (ofree) begin
            lvalid[la_r] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ftl_ram.sv =====
`default_nettype none
module ftl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
  import ftl_pkg::*;

  localparam int PPB = 10;
  localparam int NBLK = 16;
  localparam int NLPN = 80;
  localparam int NPHYS = NBLK * PPB;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum int {PM_VALID, PM_STALE, PM_EMPTY} page_mark_t;

  class ftl_scoreboard;
    rsp_t expected_q[$];
    int errors;
    bit map_ok[NLPN];
    int map_idx[NLPN];
    bit owner_ok[NPHYS];
    int owner_lpn[NPHYS];
    page_mark_t mark[NPHYS];
    int valid_cnt[NBLK];
    bit blk_free[NBLK];
    int wr_blk, wr_pg, free_cnt, spare;
    bit started;
    logic [31:0] page_writes;
    logic [4:0] threshold;

    function new();
      errors = 0;
      page_writes = 0;
      threshold = THRESHOLD_RESET;
      clear_tables();
    endfunction

    function void clear_tables();
      for (int i = 0; i < NLPN; i++) begin
        map_ok[i] = 0;
        map_idx[i] = 0;
      end
      for (int i = 0; i < NPHYS; i++) begin
        owner_ok[i] = 0;
        owner_lpn[i] = 0;
        mark[i] = PM_EMPTY;
      end
      for (int i = 0; i < NBLK; i++) begin
        valid_cnt[i] = 0;
        blk_free[i] = 1;
      end
      wr_blk = 0;
      wr_pg = 0;
      started = 0;
      free_cnt = NBLK;
      spare = NBLK - 1;
    endfunction

    function void push(logic [1:0] kind, int sb, int sp, int db, int dp, int lpn,
                       logic [1:0] st, bit lst);
      rsp_t r;
      r.kind = kind;
      r.src_block = sb[3:0];
      r.src_page = sp[3:0];
      r.dst_block = db[3:0];
      r.dst_page = dp[3:0];
      r.moved_logical_page = lpn[6:0];
      r.status = st;
      r.flash_write_count = page_writes;
      r.last = lst;
      expected_q.push_back(r);
    endfunction

    function void program_page(int blk, int pg, int lpn, bit owned);
      int idx;
      idx = blk * PPB + pg;
      mark[idx] = PM_VALID;
      valid_cnt[blk]++;
      if (owned && lpn < NLPN) begin
        owner_ok[idx] = 1;
        owner_lpn[idx] = lpn;
        map_ok[lpn] = 1;
        map_idx[lpn] = idx;
      end else begin
        owner_ok[idx] = 0;
        owner_lpn[idx] = 0;
      end
      if (page_writes != 32'hFFFF_FFFF) page_writes++;
    endfunction

    // greedy pick of the victim with fewest valid pages, moved into the spare
    function logic [1:0] collect();
      int best, victim, dst, pg, src, own;
      bit found, own_ok;
      best = PPB + 1;
      victim = 0;
      pg = 0;
      found = 0;
      for (int b = 0; b < NBLK; b++) begin
        if (!blk_free[b] && b != spare && valid_cnt[b] < best) begin
          best = valid_cnt[b];
          victim = b;
          found = 1;
        end
      end
      if (!found) return ST_NO_FREE;
      dst = spare;
      blk_free[dst] = 0;
      valid_cnt[dst] = 0;
      for (int i = 0; i < PPB; i++) begin
        src = victim * PPB + i;
        if (mark[src] == PM_VALID && pg < PPB) begin
          own = owner_lpn[src];
          own_ok = owner_ok[src];
          owner_ok[src] = 0;
          owner_lpn[src] = 0;
          program_page(dst, pg, own, own_ok);
          push(KIND_MOVE, victim, i, dst, pg, own_ok ? own : 0, ST_OK, 0);
          pg++;
        end
      end
      for (int i = 0; i < PPB; i++) begin
        mark[victim * PPB + i] = PM_EMPTY;
        owner_ok[victim * PPB + i] = 0;
        owner_lpn[victim * PPB + i] = 0;
      end
      valid_cnt[victim] = 0;
      blk_free[victim] = 1;
      if (free_cnt < NBLK) free_cnt++;
      spare = victim;
      wr_blk = dst;
      wr_pg = pg;
      if (free_cnt > 0) free_cnt--;
      if (pg >= PPB) begin
        wr_pg = PPB - 1;
        return ST_GC_FULL;
      end
      return ST_OK;
    endfunction

    function void write_page(int lpn);
      logic [1:0] st;
      int idx, b;
      st = ST_OK;
      if (lpn >= NLPN) begin
        push(KIND_DONE, 0, 0, 0, 0, lpn, ST_UNMAPPED, 1);
        return;
      end
      if (map_ok[lpn]) begin
        idx = map_idx[lpn];
        if (mark[idx] == PM_VALID) begin
          mark[idx] = PM_STALE;
          if (valid_cnt[idx / PPB] > 0) valid_cnt[idx / PPB]--;
        end
      end
      if (!started) begin
        started = 1;
        wr_blk = 0;
        wr_pg = 0;
        blk_free[0] = 0;
        valid_cnt[0] = 0;
        if (free_cnt > 0) free_cnt--;
      end else if (wr_pg >= PPB - 1) begin
        if (free_cnt <= threshold) begin
          st = collect();
        end else begin
          st = ST_NO_FREE;
          for (int i = 0; i < NBLK; i++) begin
            b = (wr_blk + i) % NBLK;
            if (st != ST_OK && blk_free[b] && b != spare) begin
              wr_blk = b;
              wr_pg = 0;
              blk_free[b] = 0;
              valid_cnt[b] = 0;
              if (free_cnt > 0) free_cnt--;
              st = ST_OK;
            end
          end
        end
      end else begin
        wr_pg++;
      end
      if (st != ST_OK) begin
        map_ok[lpn] = 0;
        map_idx[lpn] = 0;
        push(KIND_DONE, 0, 0, 0, 0, lpn, st, 1);
      end else begin
        program_page(wr_blk, wr_pg, lpn, 1);
        push(KIND_DONE, 0, 0, wr_blk, wr_pg, lpn, ST_OK, 1);
      end
    endfunction

    function void note_request(req_t r);
      int lpn;
      lpn = r.logical_page;
      case (r.operation)
        OP_READ: begin
          if (lpn < NLPN && map_ok[lpn])
            push(KIND_READ, 0, 0, map_idx[lpn] / PPB, map_idx[lpn] % PPB, lpn, ST_OK, 1);
          else
            push(KIND_READ, 0, 0, 0, 0, lpn, ST_UNMAPPED, 1);
        end
        OP_WRITE: write_page(lpn);
        OP_FORMAT: begin
          clear_tables();
          push(KIND_DONE, 0, 0, 0, 0, 0, ST_OK, 1);
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s expected %0d actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result kind %0d", a.kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("kind", e.kind, a.kind);
      cmp("src_block", e.src_block, a.src_block);
      cmp("src_page", e.src_page, a.src_page);
      cmp("dst_block", e.dst_block, a.dst_block);
      cmp("dst_page", e.dst_page, a.dst_page);
      cmp("moved_logical_page", e.moved_logical_page, a.moved_logical_page);
      cmp("status", e.status, a.status);
      cmp("flash_write_count", e.flash_write_count, a.flash_write_count);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  req_t in_data;
  rsp_t out_data;
  logic [4:0] cfg_data;

  ftl_scoreboard sb;
  bit quiet;
  bit long_hold;
  bit gaps_on;

  page_mapping_ftl_with_greedy_gc_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_top failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall in random bursts
  initial begin
    int cnt;
    bit st;
    cnt = 0;
    st = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (cnt == 0) begin
        cnt = $urandom_range(1, 12);
        st = ($urandom_range(0, 2) == 0);
      end
      cnt--;
      out_stall <= long_hold || (!quiet && st);
    end
  end

  task automatic send_request(logic [1:0] op, logic [6:0] lpn);
    int gap;
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data.operation <= op;
    in_data.logical_page <= lpn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request('{operation: op, logical_page: lpn});
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    // a trailing request with no result may still be in flight
    repeat (150) @(posedge clk);
  endtask

  task automatic set_threshold(logic [4:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.threshold = v;
  endtask

  task automatic random_writes(int n, int span);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: send_request(OP_READ, 7'($urandom_range(0, 127)));
        1: send_request(OP_NONE, 7'($urandom_range(0, 127)));
        2: send_request(OP_WRITE, 7'($urandom_range(80, 127)));
        3, 4: send_request(OP_READ, 7'($urandom_range(0, span)));
        default: send_request(OP_WRITE, 7'($urandom_range(0, span)));
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    quiet = 0;
    long_hold = 0;
    gaps_on = 1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: unmapped reads, bad addresses, no-op, first write, format
    send_request(OP_READ, 7'd0);
    send_request(OP_READ, 7'd127);
    send_request(OP_WRITE, 7'd127);
    send_request(OP_NONE, 7'd127);
    send_request(OP_WRITE, 7'd0);
    send_request(OP_READ, 7'd0);
    send_request(OP_WRITE, 7'd79);
    send_request(OP_WRITE, 7'd0);
    send_request(OP_READ, 7'd79);
    send_request(OP_FORMAT, 7'd0);
    send_request(OP_READ, 7'd79);
    send_request(OP_WRITE, 7'd42);
    drain();

    // every write to a full write block collects; a victim full of valid pages overflows the spare
    set_threshold(5'd16);
    send_request(OP_FORMAT, 7'd127);
    for (int i = 0; i < 22; i++) send_request(OP_WRITE, i[6:0]);
    drain();

    // receiver holds off while requests keep coming
    fork
      begin
        long_hold = 1;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      random_writes(20, 15);
    join
    drain();

    // never collect: free block search only
    set_threshold(5'd0);
    send_request(OP_FORMAT, 7'd0);
    random_writes(25, 79);
    drain();

    set_threshold(5'd15);
    random_writes(10, 30);
    drain();

    set_threshold(THRESHOLD_RESET);
    send_request(OP_FORMAT, 7'd0);
    random_writes(12, 25);
    drain();

    set_threshold(5'($urandom_range(1, 16)));
    quiet = 1;
    random_writes(10, 79);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ftl_pkg.sv
rtl/ftl_ram.sv
rtl/page_mapping_ftl_with_greedy_gc_core.sv
tb/tb_top.sv
